// ----- hw/rtl/ehd_pkg.sv -----
`default_nettype none

package ehd_pkg;

  // Holiday codes, in the order in which they leave the block.
  localparam int unsigned NumHolidays = 6;
  localparam int unsigned HolidayW    = 3;

  localparam logic [HolidayW-1:0] HolEaster       = 3'd0;
  localparam logic [HolidayW-1:0] HolCarnivalBeg  = 3'd1;
  localparam logic [HolidayW-1:0] HolCarnivalEnd  = 3'd2;
  localparam logic [HolidayW-1:0] HolGoodFriday   = 3'd3;
  localparam logic [HolidayW-1:0] HolWhitsuntide  = 3'd4;
  localparam logic [HolidayW-1:0] HolAscension    = 3'd5;

  localparam int unsigned YearW      = 14;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned DayW       = 5;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic                ld_year;
    logic                ld_abc;
    logic                ld_g;
    logic                ld_h;
    logic                ld_l;
    logic                ld_doy;
    logic                emit;
    logic [HolidayW-1:0] idx;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ehd_ctrl.sv -----
`default_nettype none

module ehd_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire ehd_pkg::status_t status,
  output ehd_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABC,
    ST_G,
    ST_H,
    ST_L,
    ST_DOY,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [ehd_pkg::HolidayW-1:0] idx;
  logic                         emit;

  assign emit     = (state == ST_EMIT) && status.out_free;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.ld_year = (state == ST_IDLE) && in_valid;
    cmd.ld_abc  = (state == ST_ABC);
    cmd.ld_g    = (state == ST_G);
    cmd.ld_h    = (state == ST_H);
    cmd.ld_l    = (state == ST_L);
    cmd.ld_doy  = (state == ST_DOY);
    cmd.emit    = emit;
    cmd.idx     = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ABC;
          end
        end
        ST_ABC:  state <= ST_G;
        ST_G:    state <= ST_H;
        ST_H:    state <= ST_L;
        ST_L:    state <= ST_DOY;
        ST_DOY: begin
          state <= ST_EMIT;
          idx   <= '0;
        end
        ST_EMIT: begin
          if (emit) begin
            if (idx == ehd_pkg::HolAscension) begin
              state <= ST_IDLE;
              idx   <= '0;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ehd_datapath.sv -----
`default_nettype none

module ehd_datapath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire ehd_pkg::cmd_t               cmd,
  output ehd_pkg::status_t                 status,
  input  wire  [ehd_pkg::YearW-1:0]        year_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [ehd_pkg::HolidayW-1:0]     out_holiday,
  output logic [ehd_pkg::MonthW-1:0]       out_month,
  output logic [ehd_pkg::DayW-1:0]         out_day,
  output logic                             out_last
);

  localparam logic [13:0] YearMin = 14'd1583;
  localparam logic [13:0] YearMax = 14'd9999;
  // Reciprocals scaled by powers of two; each is exact over its input range.
  localparam logic [28:0] Recip19  = 29'd27595;  // >> 19
  localparam logic [26:0] Recip100 = 27'd5243;   // >> 19
  localparam logic [14:0] Recip3   = 15'd171;    // >> 9
  localparam logic [19:0] Recip30  = 20'd1093;   // >> 15
  localparam logic [13:0] Recip7   = 14'd147;    // >> 10

  logic [13:0] year_r;
  logic [4:0]  a_r;
  logic [6:0]  b_r;
  logic [6:0]  c_r;
  logic [5:0]  g_r;
  logic        leap_r;
  logic [4:0]  h_r;
  logic [2:0]  l_r;
  logic [7:0]  doy_r;

  // Year saturation on load.
  logic [13:0] year_sat;
  always_comb begin
    priority if (year_in < YearMin) begin
      year_sat = YearMin;
    end else if (year_in > YearMax) begin
      year_sat = YearMax;
    end else begin
      year_sat = year_in;
    end
  end

  // a = y mod 19, b = y div 100, c = y mod 100.
  logic [28:0] q19_prod;
  logic [26:0] q100_prod;
  logic [9:0]  q19;
  logic [6:0]  q100;
  logic [13:0] a_full;
  logic [13:0] c_full;
  assign q19_prod  = {15'd0, year_r} * Recip19;
  assign q100_prod = {13'd0, year_r} * Recip100;
  assign q19       = q19_prod[28:19];
  assign q100      = q100_prod[25:19];
  assign a_full    = year_r - 14'({4'd0, q19} * 14'd19);
  assign c_full    = year_r - 14'({7'd0, q100} * 14'd100);

  // f = (b + 8) div 25, g = (b - f + 1) div 3.
  logic [6:0]  b8;
  logic [2:0]  f;
  logic [6:0]  gv;
  logic [14:0] g_prod;
  assign b8 = b_r + 7'd8;
  assign f  = 3'(b8 >= 7'd25) + 3'(b8 >= 7'd50) + 3'(b8 >= 7'd75) + 3'(b8 >= 7'd100);
  assign gv = b_r - 7'(f) + 7'd1;
  assign g_prod = {8'd0, gv} * Recip3;

  // Gregorian leap rule: divisible by four, and century years only when b mod 4 is 0.
  logic leap;
  assign leap = (year_r[1:0] == 2'd0) && ((c_r != 7'd0) || (b_r[1:0] == 2'd0));

  // h = (19a + b - d - g + 15) mod 30.
  logic [9:0]  hv;
  logic [19:0] h_prod;
  logic [3:0]  h_q;
  logic [9:0]  h_full;
  assign hv     = 10'({5'd0, a_r} * 10'd19) + 10'(b_r) - 10'(b_r[6:2]) - 10'(g_r) + 10'd15;
  assign h_prod = {10'd0, hv} * Recip30;
  assign h_q    = h_prod[18:15];
  assign h_full = hv - 10'({6'd0, h_q} * 10'd30);

  // l = (32 + 2e + 2i - h - k) mod 7.
  logic [6:0]  lv;
  logic [13:0] l_prod;
  logic [3:0]  l_q;
  logic [6:0]  l_full;
  assign lv     = 7'd32 + {4'd0, b_r[1:0], 1'b0} + {1'b0, c_r[6:2], 1'b0} - 7'(h_r)
                - 7'(c_r[1:0]);
  assign l_prod = {7'd0, lv} * Recip7;
  assign l_q    = l_prod[13:10];
  assign l_full = lv - 7'({3'd0, l_q} * 7'd7);

  // m, then Easter as month and day, then day of the year.
  logic [8:0] mv;
  logic       m;
  logic [7:0] base;
  logic       april;
  logic [4:0] e_day;
  logic [7:0] doy;
  assign mv    = 9'(a_r) + 9'({4'd0, h_r} * 9'd11) + 9'({6'd0, l_r} * 9'd22);
  assign m     = (mv >= 9'd451);
  assign base  = 8'(h_r) + 8'(l_r) + 8'd114 - (m ? 8'd7 : 8'd0);
  assign april = (base >= 8'd124);
  assign e_day = april ? 5'(base - 8'd123) : 5'(base - 8'd92);
  assign doy   = 8'd59 + 8'(leap_r) + (april ? 8'd31 : 8'd0) + 8'(e_day);

  // Offset of each holiday from Easter, two's complement.
  logic [7:0] offset;
  always_comb begin
    unique case (cmd.idx)
      ehd_pkg::HolEaster:      offset = 8'd0;
      ehd_pkg::HolCarnivalBeg: offset = 8'(-49);
      ehd_pkg::HolCarnivalEnd: offset = 8'(-47);
      ehd_pkg::HolGoodFriday:  offset = 8'(-2);
      ehd_pkg::HolWhitsuntide: offset = 8'd49;
      ehd_pkg::HolAscension:   offset = 8'd39;
      default:                 offset = 8'd0;
    endcase
  end

  // Day of year back to month and day; all feasts fall from February to June.
  logic [7:0] day;
  logic [7:0] st_mar;
  logic [7:0] st_apr;
  logic [7:0] st_may;
  logic [7:0] st_jun;
  logic [3:0] mon;
  logic [7:0] dd;
  assign day    = doy_r + offset;
  assign st_mar = 8'd59  + 8'(leap_r);
  assign st_apr = 8'd90  + 8'(leap_r);
  assign st_may = 8'd120 + 8'(leap_r);
  assign st_jun = 8'd151 + 8'(leap_r);

  always_comb begin
    priority if (day > st_jun) begin
      mon = 4'd6;
      dd  = day - st_jun;
    end else if (day > st_may) begin
      mon = 4'd5;
      dd  = day - st_may;
    end else if (day > st_apr) begin
      mon = 4'd4;
      dd  = day - st_apr;
    end else if (day > st_mar) begin
      mon = 4'd3;
      dd  = day - st_mar;
    end else if (day > 8'd31) begin
      mon = 4'd2;
      dd  = day - 8'd31;
    end else begin
      mon = 4'd1;
      dd  = day;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.ld_year) begin
      year_r <= year_sat;
    end
    if (cmd.ld_abc) begin
      a_r <= a_full[4:0];
      b_r <= q100;
      c_r <= c_full[6:0];
    end
    if (cmd.ld_g) begin
      g_r    <= g_prod[14:9];
      leap_r <= leap;
    end
    if (cmd.ld_h) begin
      h_r <= h_full[4:0];
    end
    if (cmd.ld_l) begin
      l_r <= l_full[2:0];
    end
    if (cmd.ld_doy) begin
      doy_r <= doy;
    end
    if (cmd.emit) begin
      out_holiday <= cmd.idx;
      out_month   <= mon;
      out_day     <= dd[4:0];
      out_last    <= (cmd.idx == ehd_pkg::HolAscension);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/easter_holiday_dates.sv -----
`default_nettype none

// Movable feasts of a Gregorian year.
// A year arrives as one beat on the s_axis channel. The block works out Easter
// Sunday with the anonymous Gregorian computus and sends six beats on the m_axis
// channel: Easter, carnival start, carnival end, Good Friday, Whitsuntide and
// Ascension, in that order. Each beat carries month and day in tdata, the
// holiday code in tuser, and tlast is high on the Ascension beat. Years below
// 1583 or above 9999 are treated as 1583 and 9999 respectively.
// The block takes one year at a time. After a year is accepted, a sequencer
// runs the computus through five register steps (the reciprocal multipliers
// for the divisions by 19, 100, 3, 30 and 7 each sit behind a register), and
// then loads one result a cycle into the output register while the receiver
// is ready. s_axis_tready rises again on the cycle after the sixth result has
// been loaded, so the next year can be taken while that result still waits
// in the output register.
// If the receiver stalls, the output register holds its beat and the sequencer
// waits. Reset empties the output register and returns the sequencer to idle.

module easter_holiday_dates (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [ehd_pkg::InDataW-1:0]        s_axis_tdata,   // [13:0] year
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [ehd_pkg::OutDataW-1:0]       m_axis_tdata,   // [3:0] month, [8:4] day_of_month
  output logic [ehd_pkg::HolidayW-1:0]       m_axis_tuser,   // [2:0] holiday
  output logic                               m_axis_tlast
);

  ehd_pkg::cmd_t                cmd;
  ehd_pkg::status_t             status;
  logic [ehd_pkg::MonthW-1:0]   month;
  logic [ehd_pkg::DayW-1:0]     day_of_month;

  ehd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ehd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .year_in     (s_axis_tdata[ehd_pkg::YearW-1:0]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_holiday (m_axis_tuser),
    .out_month   (month),
    .out_day     (day_of_month),
    .out_last    (m_axis_tlast)
  );

  // Month in the low nibble, day above it, zero padding to two bytes.
  assign m_axis_tdata = {7'd0, day_of_month, month};

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ehd_pkg::*;

  // Clock, reset and the two stream channels of the block.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [13:0] year, [15:14] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [3:0] month, [8:4] day_of_month
  logic [HolidayW-1:0] m_axis_tuser;        // [2:0] holiday
  logic                m_axis_tlast;

  easter_holiday_dates dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // One dated feast as it should leave the block.
  typedef struct packed {
    logic [HolidayW-1:0] holiday;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     mday;
    logic                last;
  } feast_t;

  logic [YearW-1:0] years_to_send[$];   // years waiting for the driver
  feast_t           feasts_due[$];      // dates still owed by the block, oldest first
  int               failures = 0;
  logic             calm = 1'b0;        // set near the end: no more idling on either side

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor.
  // ---------------------------------------------------------------------------

  function automatic bit leap_year(int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int month_length(int unsigned yr, int mon);
    if (mon == 2) return leap_year(yr) ? 29 : 28;
    if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
    return 31;
  endfunction

  // Distance in days of each feast from Easter Sunday. Carnival end is two
  // days after carnival start, and Ascension ten days before Whitsuntide.
  function automatic int days_from_easter(logic [HolidayW-1:0] hol);
    case (hol)
      HolEaster:      return 0;
      HolCarnivalBeg: return -49;
      HolCarnivalEnd: return -47;
      HolGoodFriday:  return -2;
      HolWhitsuntide: return 49;
      HolAscension:   return 39;
      default:        return 0;
    endcase
  endfunction

  // Works out the six feasts of one year and queues them in the order in which
  // the block must send them.
  task automatic predict_feasts(input logic [YearW-1:0] raw_year);
    int unsigned yr, a, b, c, d, e, f, g, h, i, k, l, m, packed_date;
    int          easter_doy, doy, mon;
    feast_t      item;
    yr = raw_year;
    // Years outside the Gregorian range that the block supports are clamped.
    if (yr < 1583) yr = 1583;
    if (yr > 9999) yr = 9999;

    // Anonymous Gregorian computus; the result packs month * 31 + day - 1.
    a = yr % 19;
    b = yr / 100;
    c = yr % 100;
    d = b / 4;
    e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4;
    k = c % 4;
    l = (32 + 2 * e + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    packed_date = h + l - 7 * m + 114;

    easter_doy = packed_date % 31 + 1;
    for (int mo = 1; mo < packed_date / 31; mo++) easter_doy += month_length(yr, mo);

    for (int n = 0; n < NumHolidays; n++) begin
      item.holiday = HolidayW'(n);
      doy = easter_doy + days_from_easter(item.holiday);
      // Walk the months; every feast lies between February and June.
      mon = 1;
      while (mon < 12 && doy > month_length(yr, mon)) begin
        doy -= month_length(yr, mon);
        mon++;
      end
      item.month = MonthW'(mon);
      item.mday  = DayW'(doy);
      item.last  = (item.holiday == HolAscension);
      feasts_due.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one year at a time on the input channel. Once a beat has
  // been taken its feasts are predicted straight away, so the expectations are
  // queued long before the block can send the first result. Gaps are inserted
  // between beats at random, except near the end.
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin
    logic              nxt_valid;
    logic [InDataW-1:0] nxt_data;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_feasts(s_axis_tdata[YearW-1:0]);
        nxt_valid = 1'b0;
      end
      // A new beat is only considered once the current one has gone, so the
      // valid line is never withdrawn while a beat is on offer.
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (years_to_send.size() > 0) begin
          if (!calm && $urandom_range(0, 4) == 0) begin
            src_gap = $urandom_range(0, 9);
          end else begin
            nxt_data  = {{(InDataW-YearW){1'b0}}, years_to_send.pop_front()};
            nxt_valid = 1'b1;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      calm <= (years_to_send.size() < 40);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes each result beat, checks it field by field against the
  // oldest expected feast and drives the receiver's ready with random stalls.
  // ---------------------------------------------------------------------------
  int sink_gap = 0;

  always @(posedge clk) begin
    feast_t seen, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.holiday = m_axis_tuser;
        seen.month   = m_axis_tdata[3:0];
        seen.mday    = m_axis_tdata[8:4];
        seen.last    = m_axis_tlast;
        if (feasts_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: holiday %0d month %0d day %0d last %0b",
                   $time, seen.holiday, seen.month, seen.mday, seen.last);
          failures++;
        end else begin
          want = feasts_due.pop_front();
          if (seen.holiday !== want.holiday) begin
            $display("%0t: holiday expected %0d, actual %0d", $time, want.holiday, seen.holiday);
            failures++;
          end
          if (seen.month !== want.month) begin
            $display("%0t: month of holiday %0d expected %0d, actual %0d",
                     $time, want.holiday, want.month, seen.month);
            failures++;
          end
          if (seen.mday !== want.mday) begin
            $display("%0t: day of holiday %0d expected %0d, actual %0d",
                     $time, want.holiday, want.mday, seen.mday);
            failures++;
          end
          if (seen.last !== want.last) begin
            $display("%0t: last flag of holiday %0d expected %0b, actual %0b",
                     $time, want.holiday, want.last, seen.last);
            failures++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    // Directed years: the range limits and what lies beyond them, century
    // years on both sides of the leap-year rule, the earliest and latest
    // possible Easter dates, years where the computus needs its 451
    // correction, and the all-ones year.
    years_to_send = '{14'd0, 14'd1582, 14'd1583, 14'd1584, 14'd1600, 14'd1700,
                      14'd1900, 14'd2000, 14'd2100, 14'd2400, 14'd1818, 14'd2285,
                      14'd1943, 14'd2038, 14'd1954, 14'd1981, 14'd2024, 14'd2019,
                      14'd8192, 14'd9999, 14'd10000, 14'd16383, 14'd8191, 14'd5555};

    // Random years, mostly inside the supported range, with a share below and
    // above it so that clamping is exercised throughout the run.
    repeat (336) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) years_to_send.push_back(YearW'($urandom_range(0, 1582)));
      else if (pick == 1) years_to_send.push_back(YearW'($urandom_range(10000, 16383)));
      else years_to_send.push_back(YearW'($urandom_range(1583, 9999)));
    end

    @(negedge rst);
    while (years_to_send.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (feasts_due.size() != 0) @(posedge clk);
    // Allow any stray beat to show up before the verdict.
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d years unsent and %0d results outstanding",
             $time, years_to_send.size(), feasts_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
